[sv/bisl_pkg.sv]
`default_nettype none

package bisl_pkg;

    localparam logic [31:0] IMG_MAGIC      = 32'h4350_5652;
    localparam logic [31:0] IMG_VERSION    = 32'd1;
    localparam logic [31:0] SRAM_START_RST = 32'd0;
    localparam logic [31:0] SRAM_BYTES_RST = 32'd65536;

    localparam logic KIND_START = 1'b0;

    // Header word positions.
    localparam logic [2:0] HW_MAGIC   = 3'd0;
    localparam logic [2:0] HW_LOAD    = 3'd1;
    localparam logic [2:0] HW_SIZE    = 3'd2;
    localparam logic [2:0] HW_ENTRY   = 3'd3;
    localparam logic [2:0] HW_SUM     = 3'd4;
    localparam logic [2:0] HW_VERSION = 3'd5;
    localparam logic [2:0] HW_RSVD0   = 3'd6;
    localparam logic [2:0] HW_RSVD1   = 3'd7;

    localparam logic [4:0] HDR_LAST_BYTE = 5'd31;
    localparam logic [1:0] LANE_TOP      = 2'd3;

    // Cycles the range check needs to settle after the SRAM window changes.
    localparam logic [1:0] CHECK_SETTLE = 2'd3;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HEADER,
        PH_PAYLOAD,
        PH_FINISHED
    } t_phase;

    typedef enum logic [2:0] {
        ST_BUSY      = 3'd0,
        ST_OK        = 3'd1,
        ST_BAD_MAGIC = 3'd2,
        ST_BAD_RANGE = 3'd3,
        ST_BAD_SIZE  = 3'd4,
        ST_BAD_ENTRY = 3'd5,
        ST_BAD_SUM   = 3'd6
    } t_status;

    typedef enum logic {
        CFG_SRAM_START = 1'b0,
        CFG_SRAM_BYTES = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic       is_start;
        logic [7:0] data;
    } t_item;

    typedef struct packed {
        logic        size_zero;
        logic        range_bad;
        logic        entry_bad;
        logic [31:0] size_m1;
    } t_verdict;

    // Merges one byte into a little-endian word at the given lane.
    function automatic logic [31:0] put_lane(input logic [31:0] word,
                                             input logic [1:0]  lane,
                                             input logic [7:0]  data);
        logic [31:0] res;
        res = word;
        case (lane)
            2'd0:    res[7:0]   = word[7:0]   | data;
            2'd1:    res[15:8]  = word[15:8]  | data;
            2'd2:    res[23:16] = word[23:16] | data;
            default: res[31:24] = word[31:24] | data;
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

[sv/bisl_in_if.sv]
`default_nettype none

interface bisl_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] data_byte;

    modport source (output valid, output kind, output data_byte, input ready);
    modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

`default_nettype wire

[sv/bisl_out_if.sv]
`default_nettype none

interface bisl_out_if;
    logic        valid;
    logic        ready;
    logic        mem_write;
    logic [31:0] mem_address;
    logic [7:0]  mem_data;
    logic        done_res;
    logic [2:0]  status;
    logic        loaded;
    logic [31:0] entry_address;

    modport source (output valid, output mem_write, output mem_address, output mem_data,
                    output done_res, output status, output loaded, output entry_address,
                    input ready);
    modport sink   (input valid, input mem_write, input mem_address, input mem_data,
                    input done_res, input status, input loaded, input entry_address,
                    output ready);
endinterface

`default_nettype wire

[sv/boot_image_stream_loader.sv]
// Each accepted word waits in the input queue and then leaves a registered result word.
// Throughput: one word per cycle unless a result waits or a hold is on, from a byte engine
// behind a two-entry queue, which takes up to two words while a result waits.
// A configuration write holds the engine while the three-stage check sees the new window.
// Reset (synchronous, active low) empties the queue, returns the loader to idle with
// status busy and nothing loaded, and restores SRAM base 0 and size 65536.
`default_nettype none

module boot_image_stream_loader import bisl_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [31:0] i_cfg_wdata,
    bisl_in_if.sink          i_in,
    bisl_out_if.source       o_res
);

    logic [31:0] r_sram_start;
    logic [31:0] r_sram_bytes;
    logic [1:0]  r_cfg_hold;
    logic        item_valid;
    t_item       item;
    logic        item_pop;
    t_verdict    verdict;
    logic [31:0] load;
    logic [31:0] size;
    logic [31:0] entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sram_start <= SRAM_START_RST;
            r_sram_bytes <= SRAM_BYTES_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_SRAM_START: r_sram_start <= i_cfg_wdata;
                CFG_SRAM_BYTES: r_sram_bytes <= i_cfg_wdata;
                default:        r_sram_start <= r_sram_start;
            endcase
        end
    end

    // The engine waits until the range check has seen the new window.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_hold <= 2'd0;
        end else if (i_cfg_we) begin
            r_cfg_hold <= CHECK_SETTLE;
        end else if (r_cfg_hold != 2'd0) begin
            r_cfg_hold <= r_cfg_hold - 2'd1;
        end
    end

    bisl_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_item_valid (item_valid),
        .o_item       (item),
        .i_item_pop   (item_pop)
    );

    bisl_check u_check (
        .i_clk        (i_clk),
        .i_load       (load),
        .i_size       (size),
        .i_entry      (entry),
        .i_sram_start (r_sram_start),
        .i_sram_bytes (r_sram_bytes),
        .o_verdict    (verdict)
    );

    bisl_engine u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_hold       (r_cfg_hold != 2'd0),
        .i_item_valid (item_valid),
        .i_item       (item),
        .o_item_pop   (item_pop),
        .i_verdict    (verdict),
        .o_load       (load),
        .o_size       (size),
        .o_entry      (entry),
        .o_res        (o_res)
    );

endmodule

`default_nettype wire

[sv/bisl_front.sv]
`default_nettype none

module bisl_front import bisl_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    bisl_in_if.sink   i_in,
    output logic      o_item_valid,
    output t_item     o_item,
    input  wire logic i_item_pop
);

    t_item      r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       push;
    t_item      in_item;

    assign i_in.ready = (r_cnt != 2'd2);
    assign push       = i_in.valid && i_in.ready;

    always_comb begin
        in_item.is_start = (i_in.kind == KIND_START);
        in_item.data     = i_in.data_byte;
    end

    assign o_item_valid = (r_cnt != 2'd0);
    assign o_item       = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_item_pop) begin
                r_rp <= ~r_rp;
            end
            case ({push, i_item_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

[sv/bisl_check.sv]
`default_nettype none

// Free-running three-stage check of the header fields against the SRAM window.
// The fields are complete after header byte 15, so the result has settled long
// before header byte 31 is processed.
module bisl_check import bisl_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic [31:0] i_load,
    input  wire logic [31:0] i_size,
    input  wire logic [31:0] i_entry,
    input  wire logic [31:0] i_sram_start,
    input  wire logic [31:0] i_sram_bytes,
    output t_verdict         o_verdict
);

    // First stage.
    logic        r_below;
    logic [31:0] r_offset;
    logic [32:0] r_end;
    logic        r_size_zero;
    logic        r_entry_lo;
    logic [31:0] r_size_m1;
    logic [31:0] r_size_a;
    // Second stage.
    logic        r_below_b;
    logic        r_off_over;
    logic [31:0] r_room;
    logic [31:0] r_size_b;
    logic        r_entry_bad;
    // Third stage.
    logic        r_range_bad;

    always_ff @(posedge i_clk) begin
        r_below     <= (i_load < i_sram_start);
        r_offset    <= i_load - i_sram_start;
        r_end       <= {1'b0, i_load} + {1'b0, i_size};
        r_size_zero <= (i_size == 32'd0);
        r_entry_lo  <= (i_entry < i_load);
        r_size_m1   <= i_size - 32'd1;
        r_size_a    <= i_size;

        r_below_b   <= r_below;
        r_off_over  <= (r_offset > i_sram_bytes);
        r_room      <= i_sram_bytes - r_offset;
        r_size_b    <= r_size_a;
        r_entry_bad <= r_entry_lo || ({1'b0, i_entry} >= r_end);

        r_range_bad <= r_below_b || r_off_over || (r_size_b > r_room);
    end

    always_comb begin
        o_verdict.size_zero = r_size_zero;
        o_verdict.range_bad = r_range_bad;
        o_verdict.entry_bad = r_entry_bad;
        o_verdict.size_m1   = r_size_m1;
    end

endmodule

`default_nettype wire

[sv/bisl_engine.sv]
`default_nettype none

module bisl_engine import bisl_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_hold,
    input  wire logic i_item_valid,
    input  wire t_item i_item,
    output logic      o_item_pop,
    input  wire t_verdict i_verdict,
    output logic [31:0] o_load,
    output logic [31:0] o_size,
    output logic [31:0] o_entry,
    bisl_out_if.source  o_res
);

    t_phase      r_phase,  n_phase;
    logic [4:0]  r_hcnt,   n_hcnt;
    logic [31:0] r_word,   n_word;
    logic        r_bad,    n_bad;
    logic [31:0] r_load,   n_load;
    logic [31:0] r_size,   n_size;
    logic [31:0] r_entry,  n_entry;
    logic [31:0] r_expect, n_expect;
    logic [31:0] r_pcnt,   n_pcnt;
    logic [31:0] r_sum,    n_sum;
    t_status     r_status, n_status;
    logic        r_loaded, n_loaded;

    logic        r_ovalid, n_ovalid;
    logic        r_owr,    n_owr;
    logic [31:0] r_oaddr,  n_oaddr;
    logic [7:0]  r_odata,  n_odata;
    logic        r_odone,  n_odone;
    t_status     r_ostat,  n_ostat;
    logic        r_oload,  n_oload;
    logic [31:0] r_oentry, n_oentry;

    logic        take;
    logic [1:0]  hdr_lane;
    logic [2:0]  hdr_idx;
    logic [31:0] hdr_word;
    logic        hdr_word_bad;
    logic        hdr_top;
    logic        hdr_last;
    logic        bad_now;
    t_status     verdict_st;
    logic [1:0]  pay_lane;
    logic [31:0] pay_word;
    logic        pay_top;
    logic        pay_last;
    logic [31:0] pay_sum;
    logic        sum_ok;

    assign take       = i_item_valid && !i_hold && (!r_ovalid || o_res.ready);
    assign o_item_pop = take;

    assign hdr_lane = r_hcnt[1:0];
    assign hdr_idx  = r_hcnt[4:2];
    assign hdr_word = put_lane(r_word, hdr_lane, i_item.data);
    assign hdr_top  = (hdr_lane == LANE_TOP);
    assign hdr_last = (r_hcnt == HDR_LAST_BYTE);

    always_comb begin
        case (hdr_idx)
            HW_MAGIC:   hdr_word_bad = (hdr_word != IMG_MAGIC);
            HW_VERSION: hdr_word_bad = (hdr_word != IMG_VERSION);
            HW_RSVD0:   hdr_word_bad = (hdr_word != 32'd0);
            HW_RSVD1:   hdr_word_bad = (hdr_word != 32'd0);
            default:    hdr_word_bad = 1'b0;
        endcase
    end

    assign bad_now = r_bad || (hdr_top && hdr_word_bad);

    always_comb begin
        if (bad_now) begin
            verdict_st = ST_BAD_MAGIC;
        end else if (i_verdict.size_zero) begin
            verdict_st = ST_BAD_SIZE;
        end else if (i_verdict.range_bad) begin
            verdict_st = ST_BAD_RANGE;
        end else if (i_verdict.entry_bad) begin
            verdict_st = ST_BAD_ENTRY;
        end else begin
            verdict_st = ST_BUSY;
        end
    end

    // The tail word is added on the last byte, zero-padded by construction.
    assign pay_lane = r_pcnt[1:0];
    assign pay_word = put_lane(r_word, pay_lane, i_item.data);
    assign pay_top  = (pay_lane == LANE_TOP);
    assign pay_last = (r_pcnt == i_verdict.size_m1);
    assign pay_sum  = r_sum + ((pay_top || pay_last) ? pay_word : 32'd0);
    assign sum_ok   = (pay_sum == r_expect);

    always_comb begin
        n_phase = r_phase;
        if (take) begin
            if (i_item.is_start) begin
                n_phase = PH_HEADER;
            end else begin
                case (r_phase)
                    PH_HEADER: begin
                        if (hdr_last) begin
                            n_phase = (verdict_st != ST_BUSY) ? PH_FINISHED : PH_PAYLOAD;
                        end
                    end
                    PH_PAYLOAD: begin
                        if (pay_last) begin
                            n_phase = PH_FINISHED;
                        end
                    end
                    default: n_phase = r_phase;
                endcase
            end
        end
    end

    always_comb begin
        n_hcnt   = r_hcnt;
        n_word   = r_word;
        n_bad    = r_bad;
        n_load   = r_load;
        n_size   = r_size;
        n_entry  = r_entry;
        n_expect = r_expect;
        n_pcnt   = r_pcnt;
        n_sum    = r_sum;
        n_status = r_status;
        n_loaded = r_loaded;
        n_ovalid = r_ovalid && !o_res.ready;
        n_owr    = r_owr;
        n_oaddr  = r_oaddr;
        n_odata  = r_odata;
        n_odone  = r_odone;
        n_ostat  = r_ostat;
        n_oload  = r_oload;
        n_oentry = r_oentry;
        if (take) begin
            n_ovalid = 1'b1;
            n_owr    = 1'b0;
            n_oaddr  = 32'd0;
            n_odata  = 8'd0;
            n_odone  = 1'b0;
            if (i_item.is_start) begin
                n_hcnt   = 5'd0;
                n_word   = 32'd0;
                n_bad    = 1'b0;
                n_load   = 32'd0;
                n_size   = 32'd0;
                n_entry  = 32'd0;
                n_expect = 32'd0;
                n_pcnt   = 32'd0;
                n_sum    = 32'd0;
                n_status = ST_BUSY;
                n_loaded = 1'b0;
            end else begin
                case (r_phase)
                    PH_HEADER: begin
                        n_word = hdr_top ? 32'd0 : hdr_word;
                        n_bad  = bad_now;
                        if (hdr_top) begin
                            case (hdr_idx)
                                HW_LOAD:  n_load   = hdr_word;
                                HW_SIZE:  n_size   = hdr_word;
                                HW_ENTRY: n_entry  = hdr_word;
                                HW_SUM:   n_expect = hdr_word;
                                default:  n_load   = r_load;
                            endcase
                        end
                        if (hdr_last) begin
                            n_hcnt = 5'd0;
                            if (verdict_st != ST_BUSY) begin
                                n_status = verdict_st;
                                n_odone  = 1'b1;
                            end else begin
                                n_pcnt = 32'd0;
                                n_sum  = 32'd0;
                            end
                        end else begin
                            n_hcnt = r_hcnt + 5'd1;
                        end
                    end
                    PH_PAYLOAD: begin
                        n_owr   = 1'b1;
                        n_oaddr = r_load + r_pcnt;
                        n_odata = i_item.data;
                        n_word  = (pay_top || pay_last) ? 32'd0 : pay_word;
                        n_sum   = pay_sum;
                        n_pcnt  = r_pcnt + 32'd1;
                        if (pay_last) begin
                            n_odone  = 1'b1;
                            n_status = sum_ok ? ST_OK : ST_BAD_SUM;
                            n_loaded = sum_ok;
                        end
                    end
                    default: n_hcnt = r_hcnt;
                endcase
            end
            n_ostat  = n_status;
            n_oload  = n_loaded;
            n_oentry = n_loaded ? n_entry : 32'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_hcnt   <= 5'd0;
            r_word   <= 32'd0;
            r_bad    <= 1'b0;
            r_load   <= 32'd0;
            r_size   <= 32'd0;
            r_entry  <= 32'd0;
            r_expect <= 32'd0;
            r_pcnt   <= 32'd0;
            r_sum    <= 32'd0;
            r_status <= ST_BUSY;
            r_loaded <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_hcnt   <= n_hcnt;
            r_word   <= n_word;
            r_bad    <= n_bad;
            r_load   <= n_load;
            r_size   <= n_size;
            r_entry  <= n_entry;
            r_expect <= n_expect;
            r_pcnt   <= n_pcnt;
            r_sum    <= n_sum;
            r_status <= n_status;
            r_loaded <= n_loaded;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_owr    <= n_owr;
        r_oaddr  <= n_oaddr;
        r_odata  <= n_odata;
        r_odone  <= n_odone;
        r_ostat  <= n_ostat;
        r_oload  <= n_oload;
        r_oentry <= n_oentry;
    end

    assign o_load  = r_load;
    assign o_size  = r_size;
    assign o_entry = r_entry;

    assign o_res.valid         = r_ovalid;
    assign o_res.mem_write     = r_owr;
    assign o_res.mem_address   = r_oaddr;
    assign o_res.mem_data      = r_odata;
    assign o_res.done_res      = r_odone;
    assign o_res.status        = r_ostat;
    assign o_res.loaded        = r_oload;
    assign o_res.entry_address = r_oentry;

endmodule

`default_nettype wire

[sim/boot_image_stream_loader_tb.sv]
`default_nettype none

module boot_image_stream_loader_tb import bisl_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int   CYCLE_LIMIT = 400000;
    localparam int   ITEM_TARGET = 1200;
    localparam int   NUM_PHASES  = 7;
    localparam logic KIND_BYTE   = ~KIND_START;

    typedef struct packed {
        logic        mem_write;
        logic [31:0] mem_address;
        logic [7:0]  mem_data;
        logic        done_res;
        logic [2:0]  status;
        logic        loaded;
        logic [31:0] entry_address;
    } t_load_result;

    // Tracks one load attempt and keeps the results that the loader owes us.
    class boot_load_scoreboard;
        logic [31:0]  sram_start;
        logic [31:0]  sram_bytes;
        t_phase       phase;
        logic [4:0]   hdr_pos;
        logic [31:0]  word_acc;
        logic         hdr_bad;
        logic [31:0]  img_load;
        logic [31:0]  img_size;
        logic [31:0]  entry;
        logic [31:0]  want_sum;
        logic [31:0]  pay_cnt;
        logic [31:0]  sum_acc;
        t_status      status;
        logic         loaded;
        t_load_result owed[$];
        int           fails;

        function new();
            sram_start = SRAM_START_RST;
            sram_bytes = SRAM_BYTES_RST;
            fails      = 0;
            clear_attempt();
            phase = PH_IDLE;
        endfunction

        function void clear_attempt();
            phase     = PH_HEADER;
            hdr_pos   = '0;
            word_acc  = '0;
            hdr_bad   = 1'b0;
            img_load  = '0;
            img_size  = '0;
            entry     = '0;
            want_sum  = '0;
            pay_cnt   = '0;
            sum_acc   = '0;
            status    = ST_BUSY;
            loaded    = 1'b0;
        endfunction

        function void set_register(t_cfg_idx idx, logic [31:0] val);
            if (idx == CFG_SRAM_START) begin
                sram_start = val;
            end else begin
                sram_bytes = val;
            end
        endfunction

        function t_status header_verdict();
            logic [31:0] offset;
            logic [32:0] img_end;
            if (hdr_bad) begin
                return ST_BAD_MAGIC;
            end
            if (img_size == 0) begin
                return ST_BAD_SIZE;
            end
            if (img_load < sram_start) begin
                return ST_BAD_RANGE;
            end
            offset = img_load - sram_start;
            if (offset > sram_bytes || img_size > sram_bytes - offset) begin
                return ST_BAD_RANGE;
            end
            // The end of the image is taken without wrap.
            img_end = {1'b0, img_load} + {1'b0, img_size};
            if (entry < img_load || {1'b0, entry} >= img_end) begin
                return ST_BAD_ENTRY;
            end
            return ST_BUSY;
        endfunction

        function void note_word(logic kind, logic [7:0] data);
            t_load_result r;
            t_status      verdict;
            logic [1:0]   lane;
            r = '0;
            if (kind == KIND_START) begin
                clear_attempt();
            end else if (phase == PH_HEADER) begin
                lane = hdr_pos[1:0];
                word_acc[8*lane +: 8] = word_acc[8*lane +: 8] | data;
                if (lane == LANE_TOP) begin
                    case (hdr_pos[4:2])
                        HW_MAGIC:   if (word_acc != IMG_MAGIC) hdr_bad = 1'b1;
                        HW_LOAD:    img_load = word_acc;
                        HW_SIZE:    img_size = word_acc;
                        HW_ENTRY:   entry = word_acc;
                        HW_SUM:     want_sum = word_acc;
                        HW_VERSION: if (word_acc != IMG_VERSION) hdr_bad = 1'b1;
                        default:    if (word_acc != 0) hdr_bad = 1'b1;
                    endcase
                    word_acc = '0;
                end
                if (hdr_pos == HDR_LAST_BYTE) begin
                    verdict = header_verdict();
                    hdr_pos = '0;
                    if (verdict != ST_BUSY) begin
                        status    = verdict;
                        phase     = PH_FINISHED;
                        r.done_res = 1'b1;
                    end else begin
                        phase   = PH_PAYLOAD;
                        pay_cnt = '0;
                        sum_acc = '0;
                    end
                end else begin
                    hdr_pos = hdr_pos + 1'b1;
                end
            end else if (phase == PH_PAYLOAD) begin
                lane          = pay_cnt[1:0];
                r.mem_write   = 1'b1;
                r.mem_address = img_load + pay_cnt;
                r.mem_data    = data;
                word_acc[8*lane +: 8] = word_acc[8*lane +: 8] | data;
                if (lane == LANE_TOP) begin
                    sum_acc  = sum_acc + word_acc;
                    word_acc = '0;
                end
                pay_cnt = pay_cnt + 1;
                if (pay_cnt == img_size) begin
                    // A partial last word counts with its upper bytes as zero.
                    if (img_size[1:0] != 2'd0) begin
                        sum_acc = sum_acc + word_acc;
                    end
                    word_acc   = '0;
                    phase      = PH_FINISHED;
                    r.done_res = 1'b1;
                    if (sum_acc == want_sum) begin
                        status = ST_OK;
                        loaded = 1'b1;
                    end else begin
                        status = ST_BAD_SUM;
                    end
                end
            end
            r.status        = status;
            r.loaded        = loaded;
            r.entry_address = loaded ? entry : '0;
            owed.push_back(r);
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("%0t: %s: got %h, expected %h", $realtime, what, got, want);
            fails++;
        endtask

        task check_result(t_load_result got);
            t_load_result want;
            if (owed.size() == 0) begin
                report("result word with nothing owed, status", 32'(got.status), 32'(ST_BUSY));
            end else begin
                want = owed.pop_front();
                if (got.mem_write !== want.mem_write)
                    report("mem_write", 32'(got.mem_write), 32'(want.mem_write));
                if (got.mem_address !== want.mem_address)
                    report("mem_address", got.mem_address, want.mem_address);
                if (got.mem_data !== want.mem_data)
                    report("mem_data", 32'(got.mem_data), 32'(want.mem_data));
                if (got.done_res !== want.done_res)
                    report("done_res", 32'(got.done_res), 32'(want.done_res));
                if (got.status !== want.status)
                    report("status", 32'(got.status), 32'(want.status));
                if (got.loaded !== want.loaded)
                    report("loaded", 32'(got.loaded), 32'(want.loaded));
                if (got.entry_address !== want.entry_address)
                    report("entry_address", got.entry_address, want.entry_address);
            end
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    t_cfg_idx    i_cfg_idx;
    logic [31:0] i_cfg_wdata;

    bisl_in_if  in_ch ();
    bisl_out_if res_ch ();

    boot_image_stream_loader uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_ch),
        .o_res       (res_ch)
    );

    boot_load_scoreboard tracker;
    int          cycle_cnt = 0;
    int          sent_cnt = 0;
    bit          tx_burst;
    logic [31:0] hdr_words [8];
    logic [7:0]  payload_bytes[$];
    logic [31:0] phase_base [NUM_PHASES];
    logic [31:0] phase_bytes [NUM_PHASES];

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("boot_image_stream_loader regression: fail");
            $finish;
        end
    end

    // Result side: takes every result word and holds ready low for a random stall.
    initial begin : result_side
        int           stall;
        bit           burst;
        t_load_result got;
        stall = 0;
        burst = 1'b0;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n) begin
                res_ch.ready <= 1'b0;
            end else begin
                if (res_ch.valid && res_ch.ready) begin
                    got.mem_write     = res_ch.mem_write;
                    got.mem_address   = res_ch.mem_address;
                    got.mem_data      = res_ch.mem_data;
                    got.done_res      = res_ch.done_res;
                    got.status        = res_ch.status;
                    got.loaded        = res_ch.loaded;
                    got.entry_address = res_ch.entry_address;
                    tracker.check_result(got);
                    if ($urandom_range(0, 63) == 0) begin
                        burst = !burst;
                    end
                    stall = burst ? 0 : $urandom_range(0, 6);
                end
                if (stall > 0) begin
                    res_ch.ready <= 1'b0;
                    stall--;
                end else begin
                    res_ch.ready <= 1'b1;
                end
            end
        end
    end

    task send_word(logic kind, logic [7:0] data);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.kind      <= kind;
        in_ch.data_byte <= data;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        tracker.note_word(kind, data);
        sent_cnt++;
    endtask

    task wait_idle();
        in_ch.valid <= 1'b0;
        while (tracker.owed.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task set_config(logic [31:0] base, logic [31:0] bytes);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_SRAM_START;
        i_cfg_wdata <= base;
        @(posedge i_clk);
        tracker.set_register(CFG_SRAM_START, base);
        i_cfg_idx   <= CFG_SRAM_BYTES;
        i_cfg_wdata <= bytes;
        @(posedge i_clk);
        tracker.set_register(CFG_SRAM_BYTES, bytes);
        i_cfg_we <= 1'b0;
    endtask

    task load_header(logic [31:0] load, logic [31:0] size, logic [31:0] entry_pt);
        hdr_words[HW_MAGIC]   = IMG_MAGIC;
        hdr_words[HW_LOAD]    = load;
        hdr_words[HW_SIZE]    = size;
        hdr_words[HW_ENTRY]   = entry_pt;
        hdr_words[HW_SUM]     = '0;
        hdr_words[HW_VERSION] = IMG_VERSION;
        hdr_words[HW_RSVD0]   = '0;
        hdr_words[HW_RSVD1]   = '0;
    endtask

    // Sends a start, the first hdr_len header bytes and pay_len random payload bytes.
    task send_image(int hdr_len, int pay_len, bit fix_sum);
        int          i;
        logic [31:0] sum;
        logic [7:0]  b;
        payload_bytes.delete();
        sum = '0;
        for (i = 0; i < pay_len; i++) begin
            b = 8'($urandom_range(0, 255));
            payload_bytes.push_back(b);
            if (i < hdr_words[HW_SIZE]) begin
                sum = sum + ({24'd0, b} << (8 * (i % 4)));
            end
        end
        if (fix_sum) begin
            hdr_words[HW_SUM] = sum;
        end
        send_word(KIND_START, 8'($urandom_range(0, 255)));
        for (i = 0; i < hdr_len; i++) begin
            send_word(KIND_BYTE, hdr_words[i / 4][8 * (i % 4) +: 8]);
        end
        foreach (payload_bytes[j]) begin
            send_word(KIND_BYTE, payload_bytes[j]);
        end
    endtask

    task random_image();
        logic [31:0] img_sz;
        logic [31:0] off;
        logic [31:0] load;
        int          hdr_len;
        int          pay_len;
        bit          fix_sum;
        tx_burst = ($urandom_range(0, 3) == 0);
        img_sz = ($urandom_range(0, 15) == 0) ? $urandom_range(25, 64) : $urandom_range(1, 24);
        if (tracker.sram_bytes >= img_sz) begin
            case ($urandom_range(0, 3))
                0:       off = '0;
                1:       off = tracker.sram_bytes - img_sz;
                default: off = $urandom_range(0, tracker.sram_bytes - img_sz);
            endcase
        end else begin
            off = $urandom;
        end
        load = tracker.sram_start + off;
        load_header(load, img_sz, load + $urandom_range(0, img_sz - 1));
        hdr_len = 32;
        pay_len = img_sz;
        fix_sum = 1'b1;
        case ($urandom_range(0, 19))
            0:  hdr_words[HW_MAGIC] = hdr_words[HW_MAGIC] ^ (32'd1 << $urandom_range(0, 31));
            1:  hdr_words[HW_VERSION] = $urandom;
            2:  hdr_words[HW_RSVD0 + $urandom_range(0, 1)] = 32'd1 << $urandom_range(0, 31);
            3:  hdr_words[HW_SIZE] = '0;
            4:  hdr_words[HW_LOAD] = $urandom;
            5:  hdr_words[HW_SIZE] = $urandom;
            6:  hdr_words[HW_ENTRY] = $urandom;
            7: begin
                fix_sum = 1'b0;
                hdr_words[HW_SUM] = $urandom;
            end
            8: begin
                hdr_len = $urandom_range(0, 31);
                pay_len = 0;
            end
            9:  pay_len = $urandom_range(0, img_sz - 1);
            10: pay_len = img_sz + $urandom_range(1, 3);
            11: repeat ($urandom_range(1, 3)) send_word(KIND_BYTE, 8'($urandom_range(0, 255)));
            default: ;
        endcase
        send_image(hdr_len, pay_len, fix_sum);
        if ($urandom_range(0, 31) == 0) begin
            wait_idle();
        end
    endtask

    initial begin
        int target;
        tracker = new();
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_idx       <= CFG_SRAM_START;
        i_cfg_wdata     <= '0;
        in_ch.valid     <= 1'b0;
        in_ch.kind      <= KIND_START;
        in_ch.data_byte <= '0;
        tx_burst = 1'b0;
        phase_base  = '{32'h0, 32'h0, 32'hFFFF_FFFF, 32'h2000_0000, $urandom,
                        32'hFFFF_FF00, 32'h0};
        phase_bytes = '{32'h0001_0000, 32'h0, 32'hFFFF_FFFF, 32'h0000_0040, $urandom,
                        32'h1000_0000, 32'hFFFF_FFFF};
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Bytes outside an attempt write nothing and leave the load state as it is.
        send_word(KIND_BYTE, 8'h00);
        send_word(KIND_BYTE, 8'hFF);
        load_header(32'h0, 32'd1, 32'h0);
        send_image(32, 1, 1'b1);
        send_word(KIND_BYTE, 8'hA5);
        // Image that ends at the top of SRAM with a partial last word.
        load_header(32'h0000_FFFB, 32'd5, 32'h0000_FFFF);
        send_image(32, 5, 1'b1);
        load_header(32'h100, 32'd8, 32'h100);
        hdr_words[HW_SUM] = 32'hDEAD_BEEF;
        send_image(32, 8, 1'b0);
        load_header(32'h0, 32'd4, 32'h0);
        hdr_words[HW_MAGIC] = hdr_words[HW_MAGIC] ^ 32'h1;
        send_image(32, 2, 1'b1);
        load_header(32'h0, 32'd4, 32'h0);
        hdr_words[HW_VERSION] = 32'd2;
        send_image(32, 2, 1'b1);
        load_header(32'h0, 32'd4, 32'h0);
        hdr_words[HW_RSVD0] = 32'h1;
        send_image(32, 0, 1'b1);
        load_header(32'h0, 32'd4, 32'h0);
        hdr_words[HW_RSVD1] = 32'h8000_0000;
        send_image(32, 0, 1'b1);
        load_header(32'h0, 32'd0, 32'h0);
        send_image(32, 2, 1'b1);
        load_header(32'h0001_0001, 32'd1, 32'h0001_0001);
        send_image(32, 1, 1'b1);
        load_header(32'h0000_FFFF, 32'd2, 32'h0000_FFFF);
        send_image(32, 2, 1'b1);
        load_header(32'h200, 32'd4, 32'h1FF);
        send_image(32, 0, 1'b1);
        load_header(32'h200, 32'd4, 32'h204);
        send_image(32, 0, 1'b1);
        // A new start drops an attempt in the header and then one in the payload.
        load_header(32'h0, 32'd4, 32'h0);
        send_image(10, 0, 1'b1);
        load_header(32'h0, 32'd16, 32'h0);
        send_image(32, 6, 1'b1);

        set_config(32'hFFFF_FF00, 32'h1000_0000);
        load_header(32'h10, 32'd4, 32'h10);
        send_image(32, 0, 1'b1);
        // Payload addresses wrap past the top of the address space.
        load_header(32'hFFFF_FFF8, 32'd16, 32'hFFFF_FFFC);
        send_image(32, 16, 1'b1);
        load_header(32'hFFFF_FFF8, 32'd16, 32'h4);
        send_image(32, 0, 1'b1);
        set_config(32'h2000_0000, 32'd8);
        load_header(32'h2000_0000, 32'd8, 32'h2000_0007);
        send_image(32, 8, 1'b1);
        set_config(32'h0, 32'hFFFF_FFFF);
        load_header(32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
        send_image(32, 5, 1'b1);

        // The remaining words are spread over the SRAM windows.
        for (int p = 0; p < NUM_PHASES; p++) begin
            set_config(phase_base[p], phase_bytes[p]);
            target = sent_cnt + (ITEM_TARGET - sent_cnt) / (NUM_PHASES - p);
            while (sent_cnt < target) begin
                random_image();
            end
        end

        wait_idle();
        repeat (8) @(posedge i_clk);
        if (tracker.fails == 0) begin
            $display("boot_image_stream_loader regression: pass");
        end else begin
            $display("boot_image_stream_loader regression: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire

[sim.f]
sv/bisl_pkg.sv
sv/bisl_in_if.sv
sv/bisl_out_if.sv
sv/bisl_front.sv
sv/bisl_check.sv
sv/bisl_engine.sv
sv/boot_image_stream_loader.sv
sim/boot_image_stream_loader_tb.sv
